/* design/tbg_pkg.sv */
package tbg_pkg;

    localparam int unsigned DataWidth = 32;
    localparam int unsigned StepWidth = 16;
    localparam int unsigned CfgIdxWidth = 3;

    localparam logic [2:0] CFG_GRAVITY  = 3'd0;
    localparam logic [2:0] CFG_MASS_A   = 3'd1;
    localparam logic [2:0] CFG_MASS_B   = 3'd2;
    localparam logic [2:0] CFG_CONTACT  = 3'd3;
    localparam logic [2:0] CFG_STEP     = 3'd4;

    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_LOAD_A = 2'd1;
    localparam logic [1:0] OP_LOAD_B = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [31:0] RST_GRAVITY = 32'd262144000;
    localparam logic [31:0] RST_MASS    = 32'd655360;
    localparam logic [31:0] RST_CONTACT = 32'd1966080;
    localparam logic [15:0] RST_STEP    = 16'd1049;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] load_pos_x;
        logic signed [31:0] load_pos_y;
        logic signed [31:0] load_vel_x;
        logic signed [31:0] load_vel_y;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] a_pos_x;
        logic signed [31:0] a_pos_y;
        logic signed [31:0] a_vel_x;
        logic signed [31:0] a_vel_y;
        logic signed [31:0] b_pos_x;
        logic signed [31:0] b_pos_y;
        logic signed [31:0] b_vel_x;
        logic signed [31:0] b_vel_y;
        logic               attracted;
    } out_word_t;

    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
        logic [6:0]  steps;
    } div_req_t;

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        if (v > 34'sh0_7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        else if (v < -34'sh0_8000_0000)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : v;
    endfunction

endpackage

/* design/tbg_div.sv */
module tbg_div
    import tbg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  div_req_t    req,
    output logic        busy,
    output logic [63:0] quot,
    output logic        ovf
);
    logic [63:0] q_reg, q_next;
    logic [64:0] r_reg, r_next;
    logic [63:0] n_reg, n_next;
    logic [63:0] d_reg, d_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        ovf_reg, ovf_next;
    logic [64:0] r_sh;

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        n_next = n_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        ovf_next = ovf_reg;
        r_sh = {r_reg[63:0], n_reg[63]};
        if (req.start)
        begin
            q_next = '0;
            r_next = '0;
            n_next = req.num;
            d_next = req.den;
            cnt_next = req.steps;
            ovf_next = 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            n_next = {n_reg[62:0], 1'b0};
            ovf_next = ovf_reg | q_reg[63];
            if (r_sh >= {1'b0, d_reg})
            begin
                r_next = r_sh - {1'b0, d_reg};
                q_next = {q_reg[62:0], 1'b1};
            end
            else
            begin
                r_next = r_sh;
                q_next = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        n_reg <= n_next;
        d_reg <= d_next;
        ovf_reg <= ovf_next;
    end

    assign busy = (cnt_reg != '0);
    assign quot = q_reg;
    assign ovf = ovf_reg;
endmodule

/* design/tbg_sqrt.sv */
module tbg_sqrt
    import tbg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] rad,
    output logic        busy,
    output logic [31:0] root
);
    logic [63:0] v_reg, v_next;
    logic [63:0] res_reg, res_next;
    logic [63:0] bit_reg, bit_next;
    logic        act_reg, act_next;

    always_comb
    begin
        v_next = v_reg;
        res_next = res_reg;
        bit_next = bit_reg;
        act_next = act_reg;
        if (start)
        begin
            v_next = rad;
            res_next = '0;
            bit_next = 64'h4000_0000_0000_0000;
            act_next = 1'b1;
        end
        else if (act_reg)
        begin
            if (v_reg >= res_reg + bit_reg)
            begin
                v_next = v_reg - (res_reg + bit_reg);
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
                res_next = res_reg >> 1;
            bit_next = bit_reg >> 2;
            if (bit_reg[0])
                act_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            act_reg <= 1'b0;
        else
            act_reg <= act_next;
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign busy = act_reg;
    assign root = res_reg[31:0];
endmodule

/* design/two_body_gravity_step_core.sv */
// Two-body gravity step, signed Q16.16. Each input word is a tick or a load of
// one body; each gives one output word with both bodies' state. Loads and
// opcode 3 go straight to loading the output. A tick within contact distance
// forms the differences, their squares and the square root, then updates
// each position coordinate in turn and loads the output. Beyond contact
// distance it adds two 80-step divisions for the pull factors and four
// 64-step divisions for the velocity changes, on one shared restoring
// divider, before the position updates. Ready is low while a word is in
// work, and a full output register holds the block until taken.
module two_body_gravity_step_core
    import tbg_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  in_word_t               in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output out_word_t              out_data,
    input  logic                   cfg_we,
    input  logic [CfgIdxWidth-1:0] cfg_index,
    input  logic [DataWidth-1:0]   cfg_data
);
    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_DIFF  = 9'b000000010,
        S_SQ    = 9'b000000100,
        S_SQRT  = 9'b000001000,
        S_KDIV  = 9'b000010000,
        S_PDIV  = 9'b000100000,
        S_POS   = 9'b001000000,
        S_OUT   = 9'b010000000,
        S_SQW   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [31:0] grav_reg, ma_reg, mb_reg, cont_reg;
    logic [15:0] dt_reg;

    logic signed [31:0] ax_reg, ay_reg, avx_reg, avy_reg;
    logic signed [31:0] bx_reg, by_reg, bvx_reg, bvy_reg;
    logic signed [31:0] ax_next, ay_next, avx_next, avy_next;
    logic signed [31:0] bx_next, by_next, bvx_next, bvy_next;
    logic signed [31:0] dx_reg, dy_reg, dx_next, dy_next;
    logic [63:0] s_reg, s_next;
    logic [63:0] sqx_reg, sqx_next;
    logic [31:0] d_reg, d_next;
    logic [31:0] ka_reg, kb_reg, ka_next, kb_next;
    logic [2:0]  sub_reg, sub_next;
    logic        go_reg, go_next;
    logic        att_reg, att_next;
    logic        busy_out_reg, busy_out_next;

    div_req_t    dreq;
    logic        div_busy;
    logic [63:0] div_q;
    logic        div_ovf;
    logic        sq_start, sq_busy;
    logic [31:0] sq_root;

    logic [63:0] mul_p;
    logic [31:0] mul_a, mul_b;
    logic [31:0] kq;
    logic [31:0] pq;
    logic signed [31:0] pdelta;
    logic signed [31:0] vin, pin;
    logic [47:0] pm;

    tbg_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (dreq),
        .busy (div_busy),
        .quot (div_q),
        .ovf  (div_ovf)
    );

    tbg_sqrt u_sqrt (
        .clk  (clk),
        .rst_n(rst_n),
        .start(sq_start),
        .rad  (s_reg),
        .busy (sq_busy),
        .root (sq_root)
    );

    assign mul_p = 64'(mul_a) * 64'(mul_b);
    assign kq = (div_ovf || div_q[63:32] != '0) ? 32'hFFFF_FFFF : div_q[31:0];
    assign pq = (div_q > 64'h8000_0000) ? 32'h8000_0000 : div_q[31:0];

    always_comb
    begin
        case (sub_reg[1:0])
            2'd0: vin = avx_reg;
            2'd1: vin = avy_reg;
            2'd2: vin = bvx_reg;
            default: vin = bvy_reg;
        endcase
        case (sub_reg[1:0])
            2'd0: pin = ax_reg;
            2'd1: pin = ay_reg;
            2'd2: pin = bx_reg;
            default: pin = by_reg;
        endcase
        pdelta = sub_reg[0] ? dy_reg : dx_reg;
        pm = 48'(mag32(vin)) * 48'(dt_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        {ax_next, ay_next, avx_next, avy_next} = {ax_reg, ay_reg, avx_reg, avy_reg};
        {bx_next, by_next, bvx_next, bvy_next} = {bx_reg, by_reg, bvx_reg, bvy_reg};
        dx_next = dx_reg;
        dy_next = dy_reg;
        s_next = s_reg;
        sqx_next = sqx_reg;
        d_next = d_reg;
        ka_next = ka_reg;
        kb_next = kb_reg;
        sub_next = sub_reg;
        go_next = 1'b0;
        att_next = att_reg;
        busy_out_next = busy_out_reg;
        dreq = '0;
        sq_start = 1'b0;
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    att_next = 1'b0;
                    case (in_data.opcode)
                        OP_LOAD_A:
                        begin
                            ax_next = in_data.load_pos_x;
                            ay_next = in_data.load_pos_y;
                            avx_next = in_data.load_vel_x;
                            avy_next = in_data.load_vel_y;
                            state_next = S_OUT;
                        end
                        OP_LOAD_B:
                        begin
                            bx_next = in_data.load_pos_x;
                            by_next = in_data.load_pos_y;
                            bvx_next = in_data.load_vel_x;
                            bvy_next = in_data.load_vel_y;
                            state_next = S_OUT;
                        end
                        OP_TICK:
                            state_next = S_DIFF;
                        default:
                            state_next = S_OUT;
                    endcase
                end
            end
            S_DIFF:
            begin
                dx_next = sat32(34'(bx_reg) - 34'(ax_reg));
                dy_next = sat32(34'(by_reg) - 34'(ay_reg));
                sub_next = '0;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                mul_a = mag32(dx_reg);
                mul_b = mag32(dx_reg);
                sqx_next = mul_p;
                state_next = S_SQW;
            end
            S_SQW:
            begin
                mul_a = mag32(dy_reg);
                mul_b = mag32(dy_reg);
                s_next = sqx_reg + mul_p;
                go_next = 1'b1;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                sq_start = go_reg;
                if (!go_reg && !sq_busy)
                begin
                    d_next = sq_root;
                    if (sq_root > cont_reg)
                    begin
                        att_next = 1'b1;
                        sub_next = '0;
                        go_next = 1'b1;
                        state_next = S_KDIV;
                    end
                    else
                    begin
                        sub_next = '0;
                        state_next = S_POS;
                    end
                end
            end
            S_KDIV:
            begin
                mul_a = grav_reg;
                mul_b = sub_reg[0] ? ma_reg : mb_reg;
                if (go_reg)
                begin
                    dreq.start = 1'b1;
                    dreq.num = mul_p;
                    dreq.den = s_reg;
                    dreq.steps = 7'd80;
                end
                else if (!div_busy)
                begin
                    dreq.start = 1'b0;
                    if (sub_reg[0])
                    begin
                        kb_next = kq;
                        sub_next = '0;
                        state_next = S_PDIV;
                    end
                    else
                    begin
                        ka_next = kq;
                        sub_next = 3'd1;
                    end
                    go_next = 1'b1;
                end
            end
            S_PDIV:
            begin
                mul_a = sub_reg[1] ? kb_reg : ka_reg;
                mul_b = mag32(pdelta);
                if (go_reg)
                begin
                    dreq.start = 1'b1;
                    dreq.num = mul_p;
                    dreq.den = 64'(d_reg);
                    dreq.steps = 7'd64;
                end
                else if (!div_busy)
                begin
                    case (sub_reg[1:0])
                        2'd0: avx_next = sat32(34'(avx_reg) + (dx_reg[31] ? -34'(pq) : 34'(pq)));
                        2'd1: avy_next = sat32(34'(avy_reg) + (dy_reg[31] ? -34'(pq) : 34'(pq)));
                        2'd2: bvx_next = sat32(34'(bvx_reg) - (dx_reg[31] ? -34'(pq) : 34'(pq)));
                        default: bvy_next = sat32(34'(bvy_reg) - (dy_reg[31] ? -34'(pq) : 34'(pq)));
                    endcase
                    if (sub_reg[1:0] == 2'd3)
                    begin
                        sub_next = '0;
                        state_next = S_POS;
                    end
                    else
                    begin
                        sub_next = sub_reg + 3'd1;
                        go_next = 1'b1;
                    end
                end
            end
            S_POS:
            begin
                case (sub_reg[1:0])
                    2'd0: ax_next = sat32(34'(pin) + (vin[31] ? -34'(pm[47:16]) : 34'(pm[47:16])));
                    2'd1: ay_next = sat32(34'(pin) + (vin[31] ? -34'(pm[47:16]) : 34'(pm[47:16])));
                    2'd2: bx_next = sat32(34'(pin) + (vin[31] ? -34'(pm[47:16]) : 34'(pm[47:16])));
                    default: by_next = sat32(34'(pin) + (vin[31] ? -34'(pm[47:16]) : 34'(pm[47:16])));
                endcase
                if (sub_reg[1:0] == 2'd3)
                    state_next = S_OUT;
                else
                    sub_next = sub_reg + 3'd1;
            end
            S_OUT:
            begin
                if (!busy_out_reg || out_ready)
                begin
                    busy_out_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
        if (busy_out_reg && out_ready && !(state_reg == S_OUT))
            busy_out_next = 1'b0;
    end

    // p = k*|delta| is Q32.32-ish; k*|delta| fits 64 bits, divided by d (Q16.16)
    // gives Q16.16 directly: num = k*|delta|, scaled so quotient = k*|delta|/d.

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            go_reg <= 1'b0;
            busy_out_reg <= 1'b0;
            grav_reg <= RST_GRAVITY;
            ma_reg <= RST_MASS;
            mb_reg <= RST_MASS;
            cont_reg <= RST_CONTACT;
            dt_reg <= RST_STEP;
            ax_reg <= 32'sd19660800;
            ay_reg <= 32'sd19660800;
            avx_reg <= '0;
            avy_reg <= 32'sd2621440;
            bx_reg <= 32'sd32768000;
            by_reg <= 32'sd19660800;
            bvx_reg <= '0;
            bvy_reg <= -32'sd2621440;
        end
        else
        begin
            state_reg <= state_next;
            go_reg <= go_next;
            busy_out_reg <= busy_out_next;
            {ax_reg, ay_reg, avx_reg, avy_reg} <= {ax_next, ay_next, avx_next, avy_next};
            {bx_reg, by_reg, bvx_reg, bvy_reg} <= {bx_next, by_next, bvx_next, bvy_next};
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_GRAVITY: grav_reg <= cfg_data;
                    CFG_MASS_A:  ma_reg <= cfg_data;
                    CFG_MASS_B:  mb_reg <= cfg_data;
                    CFG_CONTACT: cont_reg <= cfg_data;
                    CFG_STEP:    dt_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg <= dx_next;
        dy_reg <= dy_next;
        s_reg <= s_next;
        sqx_reg <= sqx_next;
        d_reg <= d_next;
        ka_reg <= ka_next;
        kb_reg <= kb_next;
        sub_reg <= sub_next;
        att_reg <= att_next;
        if (state_reg == S_OUT && (!busy_out_reg || out_ready))
        begin
            out_data.a_pos_x <= ax_reg;
            out_data.a_pos_y <= ay_reg;
            out_data.a_vel_x <= avx_reg;
            out_data.a_vel_y <= avy_reg;
            out_data.b_pos_x <= bx_reg;
            out_data.b_pos_y <= by_reg;
            out_data.b_vel_x <= bvx_reg;
            out_data.b_vel_y <= bvy_reg;
            out_data.attracted <= att_reg;
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = busy_out_reg;
endmodule
